FILE: rtl/core/icbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icbs_pkg
// Shared constants and controller/datapath interface types for the
// interval-censored Brier score block.
// ----------------------------------------------------------------------------
package icbs_pkg;

  localparam int MAX_TIMES_DEF = 256;
  localparam int TIME_W        = 32;
  localparam int SURV_W        = 17;
  localparam int REG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [SURV_W-1:0]     ONE_Q16       = 17'd65536;
  localparam logic [TIME_W-1:0]     HORIZON_RESET = 32'hFFFF_FFFF;
  localparam logic                  REG_HORIZON   = 1'b0;

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_SEL_INT = 2'd0;
  localparam div_sel_t DIV_SEL_S1  = 2'd1;
  localparam div_sel_t DIV_SEL_S2  = 2'd2;

  typedef struct packed {
    logic     load;
    logic     k_clr;
    logic     p_init;
    logic     rd;
    logic     step;
    logic     p1_eval;
    logic     p2_eval;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_mag;
    logic     sq;
    logic     mul;
    logic     acc;
    logic     take_s1;
    logic     clr_s1;
    logic     take_s2;
    logic     clr_s2;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_last;
    logic p1_stop;
    logic p2_stop;
    logic need_div;
    logic div_done;
    logic ts1_zero;
    logic tsall_zero;
  } status_t;

endpackage

FILE: rtl/core/icbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module icbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/icbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icbs_div
// Iterative restoring divider giving a Q1.16 quotient saturated to one,
// one quotient bit per cycle after a single saturation check.
// ----------------------------------------------------------------------------
module icbs_div
  import icbs_pkg::*;
#(
  parameter int W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  output logic              done,
  output logic [SURV_W-1:0] quo
);

  logic [W-1:0]      n_r;
  logic [W-1:0]      d_r;
  logic [W-1:0]      ds_r;
  logic [SURV_W-1:0] q_r;
  logic [4:0]        cnt_r;
  logic              chk_r;
  logic              run_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        chk_r <= 1'b1;
        cnt_r <= 5'(SURV_W);
      end else if (run_r) begin
        if (chk_r) begin
          chk_r <= 1'b0;
          if (n_r >= ds_r + d_r) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end else begin
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= num;
      d_r  <= den;
      ds_r <= den << 16;
      q_r  <= '0;
    end else if (run_r) begin
      if (chk_r) begin
        if (n_r >= ds_r + d_r) begin
          q_r <= ONE_Q16;
        end
      end else begin
        if (n_r >= ds_r) begin
          n_r <= n_r - ds_r;
          q_r <= {q_r[SURV_W-2:0], 1'b1};
        end else begin
          q_r <= {q_r[SURV_W-2:0], 1'b0};
        end
        ds_r <= ds_r >> 1;
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: rtl/core/icbs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icbs_dp
// Datapath: curve store, bound lookup, error accumulation, score division
// and result registers.
// ----------------------------------------------------------------------------
module icbs_dp
  import icbs_pkg::*;
#(
  parameter int MAX_TIMES = MAX_TIMES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output status_t           sts,
  input  logic [TIME_W-1:0] horizon,
  input  logic [TIME_W-1:0] in_left_bound,
  input  logic [TIME_W-1:0] in_right_bound,
  input  logic              in_right_infinite,
  input  logic [TIME_W-1:0] in_time_point,
  input  logic              in_time_infinite,
  input  logic [SURV_W-1:0] in_surv_value,
  output logic              out_valid,
  output logic [SURV_W-1:0] out_score_outside,
  output logic [SURV_W-1:0] out_score_all,
  output logic              out_outside_empty,
  output logic              out_all_empty
);

  localparam int AW    = $clog2(MAX_TIMES);
  localparam int CW    = $clog2(MAX_TIMES + 1);
  localparam int TS_W  = TIME_W + CW;
  localparam int ERR_W = TS_W + SURV_W;
  localparam int DW    = ERR_W + 2;
  localparam int MEM_W = 1 + TIME_W + SURV_W;
  localparam int EXT_W = TIME_W + 1;
  localparam logic [EXT_W-1:0] INF_EXT = {1'b1, {TIME_W{1'b0}}};

  localparam logic [1:0] CLS_BEFORE = 2'd0;
  localparam logic [1:0] CLS_AFTER  = 2'd1;
  localparam logic [1:0] CLS_INSIDE = 2'd2;

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     k_r;
  logic [TIME_W-1:0] left_r;
  logic [EXT_W-1:0]  right_r;
  logic              mem_we;
  logic [MEM_W-1:0]  mem_wdata;
  logic [MEM_W-1:0]  mem_rdata;
  logic [SURV_W-1:0] surv_sat;
  logic [SURV_W-1:0] cur_surv;
  logic              cur_inf;
  logic [EXT_W-1:0]  cur_ext;
  logic [EXT_W-1:0]  prev_ext_r;
  logic [SURV_W-1:0] prev_surv_r;
  logic              prev_inf_r;
  logic [EXT_W-1:0]  left_ext;
  logic [EXT_W-1:0]  hor_ext;
  logic [EXT_W-1:0]  dt_diff;
  logic [SURV_W-1:0] sl_r;
  logic [SURV_W-1:0] sr_r;
  logic [SURV_W-1:0] d_q;
  logic [TIME_W-1:0] dt_r;
  logic [1:0]        cls_r;
  logic [SURV_W-1:0] s_r;
  logic [SURV_W-1:0] m_r;
  logic [32:0]       prod_r;
  logic signed [35:0] sr_diff_s;
  logic signed [35:0] num_s;
  logic [35:0]       amag;
  logic [35:0]       rnd_int;
  logic [33:0]       sqsum;
  logic [SURV_W-1:0] sq_r;
  logic [48:0]       w_r;
  logic [ERR_W-1:0]  err1_r;
  logic [ERR_W-1:0]  err2_r;
  logic [TS_W-1:0]   ts1_r;
  logic [TS_W-1:0]   ts2_r;
  logic [TS_W:0]     ts_all;
  logic [ERR_W:0]    err_all;
  logic [DW-1:0]     div_n;
  logic [DW-1:0]     div_d;
  logic              div_done;
  logic [SURV_W-1:0] div_q;
  logic              out_valid_r;
  logic [SURV_W-1:0] score1_r;
  logic [SURV_W-1:0] score2_r;
  logic              empty1_r;
  logic              empty2_r;

  assign surv_sat  = (in_surv_value > ONE_Q16) ? ONE_Q16 : in_surv_value;
  assign mem_we    = cmd.load && (count_r < CW'(MAX_TIMES));
  assign mem_wdata = {in_time_infinite, in_time_point, surv_sat};

  icbs_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_TIMES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (mem_wdata),
    .re    (cmd.rd),
    .raddr (k_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign cur_surv = mem_rdata[SURV_W-1:0];
  assign cur_inf  = mem_rdata[MEM_W-1];
  assign cur_ext  = cur_inf ? INF_EXT : {1'b0, mem_rdata[MEM_W-2:SURV_W]};
  assign left_ext = {1'b0, left_r};
  assign hor_ext  = {1'b0, horizon};
  assign dt_diff  = cur_ext - prev_ext_r;
  assign d_q      = sl_r - sr_r;

  assign sts.k_zero     = (k_r == '0);
  assign sts.k_last     = (k_r == count_r - CW'(1));
  assign sts.p1_stop    = !sts.k_zero && (prev_ext_r > hor_ext);
  assign sts.p2_stop    = !sts.k_zero && ((cur_ext > hor_ext) || prev_inf_r);
  assign sts.need_div   = (cls_r == CLS_INSIDE) && (sl_r > sr_r);
  assign sts.div_done   = div_done;
  assign sts.ts1_zero   = (ts1_r == '0);
  assign sts.tsall_zero = (ts_all == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      k_r         <= '0;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        left_r  <= in_left_bound;
        right_r <= in_right_infinite ? INF_EXT : {1'b0, in_right_bound};
        if (mem_we) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.emit) begin
        count_r <= '0;
      end
      if (cmd.k_clr) begin
        k_r <= '0;
      end else if (cmd.step) begin
        k_r <= k_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_init) begin
      sl_r   <= ONE_Q16;
      sr_r   <= '0;
      err1_r <= '0;
      err2_r <= '0;
      ts1_r  <= '0;
      ts2_r  <= '0;
    end
    if (cmd.p1_eval) begin
      prev_ext_r  <= cur_ext;
      prev_surv_r <= cur_surv;
      prev_inf_r  <= cur_inf;
      if (!sts.k_zero && !sts.p1_stop) begin
        if ((left_ext >= prev_ext_r) && (left_ext < cur_ext)) begin
          sl_r <= prev_surv_r;
        end else if ((right_r > prev_ext_r) && (right_r <= cur_ext)) begin
          sr_r <= prev_surv_r;
        end
      end
    end
    if (cmd.p2_eval) begin
      prev_ext_r  <= cur_ext;
      prev_surv_r <= cur_surv;
      prev_inf_r  <= cur_inf;
      dt_r        <= (cur_ext > prev_ext_r) ? dt_diff[TIME_W-1:0] : '0;
      s_r         <= cur_surv;
      prod_r      <= 33'({16'd0, cur_surv} * {16'd0, d_q});
      if (cur_ext <= left_ext) begin
        cls_r <= CLS_BEFORE;
        m_r   <= ONE_Q16 - cur_surv;
      end else if (cur_ext > right_r) begin
        cls_r <= CLS_AFTER;
        m_r   <= cur_surv;
      end else begin
        cls_r <= CLS_INSIDE;
        m_r   <= sr_r;
      end
    end
    if (cmd.take_mag) begin
      m_r <= div_q;
    end
    if (cmd.sq) begin
      sq_r <= sqsum[32:16];
    end
    if (cmd.mul) begin
      w_r <= {17'd0, dt_r} * {32'd0, sq_r};
    end
    if (cmd.acc) begin
      if (cls_r == CLS_INSIDE) begin
        err2_r <= err2_r + ERR_W'(w_r);
        ts2_r  <= ts2_r + TS_W'(dt_r);
      end else begin
        err1_r <= err1_r + ERR_W'(w_r);
        ts1_r  <= ts1_r + TS_W'(dt_r);
      end
    end
    if (cmd.take_s1) begin
      score1_r <= div_q;
    end else if (cmd.clr_s1) begin
      score1_r <= '0;
    end
    if (cmd.take_s2) begin
      score2_r <= div_q;
    end else if (cmd.clr_s2) begin
      score2_r <= '0;
    end
    if (cmd.emit) begin
      empty1_r <= sts.ts1_zero;
      empty2_r <= sts.tsall_zero;
    end
  end

  assign sr_diff_s = $signed({19'd0, s_r}) - $signed({19'd0, sr_r});
  assign num_s     = $signed({3'd0, prod_r}) - (sr_diff_s <<< 16);
  assign amag      = num_s[35] ? 36'(-num_s) : 36'(num_s);
  assign rnd_int   = amag + 36'(d_q >> 1);
  assign sqsum     = {17'd0, m_r} * {17'd0, m_r} + 34'd32768;
  assign ts_all    = {1'b0, ts1_r} + {1'b0, ts2_r};
  assign err_all   = {1'b0, err1_r} + {1'b0, err2_r};

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_S1: begin
        div_n = DW'(err1_r) + DW'(ts1_r >> 1);
        div_d = DW'(ts1_r);
      end
      DIV_SEL_S2: begin
        div_n = DW'(err_all) + DW'(ts_all >> 1);
        div_d = DW'(ts_all);
      end
      default: begin
        div_n = DW'(rnd_int);
        div_d = DW'(d_q);
      end
    endcase
  end

  icbs_div #(
    .W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q)
  );

  assign out_valid         = out_valid_r;
  assign out_score_outside = score1_r;
  assign out_score_all     = score2_r;
  assign out_outside_empty = empty1_r;
  assign out_all_empty     = empty2_r;

endmodule

FILE: rtl/core/icbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icbs_ctrl
// Controller: sequences loading, the bound lookup pass, the error pass and
// the two final divisions.
// ----------------------------------------------------------------------------
module icbs_ctrl
  import icbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_last_point,
  input  status_t sts,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P1_RD  = 4'd1;
  localparam logic [3:0] S_P1_EV  = 4'd2;
  localparam logic [3:0] S_P2_RD  = 4'd3;
  localparam logic [3:0] S_P2_EV  = 4'd4;
  localparam logic [3:0] S_P2_NUM = 4'd5;
  localparam logic [3:0] S_P2_DIV = 4'd6;
  localparam logic [3:0] S_P2_SQ  = 4'd7;
  localparam logic [3:0] S_P2_MUL = 4'd8;
  localparam logic [3:0] S_P2_ACC = 4'd9;
  localparam logic [3:0] S_F1     = 4'd10;
  localparam logic [3:0] S_F1_W   = 4'd11;
  localparam logic [3:0] S_F2     = 4'd12;
  localparam logic [3:0] S_F2_W   = 4'd13;
  localparam logic [3:0] S_EMIT   = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_point) begin
            cmd.k_clr  = 1'b1;
            cmd.p_init = 1'b1;
            state_nxt  = S_P1_RD;
          end
        end
      end
      S_P1_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_P1_EV;
      end
      S_P1_EV: begin
        cmd.p1_eval = 1'b1;
        if (sts.p1_stop || sts.k_last) begin
          cmd.k_clr = 1'b1;
          state_nxt = S_P2_RD;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_P1_RD;
        end
      end
      S_P2_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_P2_EV;
      end
      S_P2_EV: begin
        if (sts.p2_stop) begin
          state_nxt = S_F1;
        end else begin
          cmd.p2_eval = 1'b1;
          if (!sts.k_zero) begin
            state_nxt = S_P2_NUM;
          end else if (sts.k_last) begin
            state_nxt = S_F1;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_P2_RD;
          end
        end
      end
      S_P2_NUM: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_INT;
          state_nxt     = S_P2_DIV;
        end else begin
          state_nxt = S_P2_SQ;
        end
      end
      S_P2_DIV: begin
        if (sts.div_done) begin
          cmd.take_mag = 1'b1;
          state_nxt    = S_P2_SQ;
        end
      end
      S_P2_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_P2_MUL;
      end
      S_P2_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_P2_ACC;
      end
      S_P2_ACC: begin
        cmd.acc = 1'b1;
        if (sts.k_last) begin
          state_nxt = S_F1;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_P2_RD;
        end
      end
      S_F1: begin
        if (sts.ts1_zero) begin
          cmd.clr_s1 = 1'b1;
          state_nxt  = S_F2;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_S1;
          state_nxt     = S_F1_W;
        end
      end
      S_F1_W: begin
        if (sts.div_done) begin
          cmd.take_s1 = 1'b1;
          state_nxt   = S_F2;
        end
      end
      S_F2: begin
        if (sts.tsall_zero) begin
          cmd.clr_s2 = 1'b1;
          state_nxt  = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_S2;
          state_nxt     = S_F2_W;
        end
      end
      S_F2_W: begin
        if (sts.div_done) begin
          cmd.take_s2 = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/core/interval_censored_brier_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_censored_brier_score
// Loads one subject's survival curve and emits its interval-censored Brier
// scores after two passes over the stored curve.
//
//   Channel  Handshake             Payload
//   input    start / busy          in_left_bound .. in_last_point
//   result   out_valid (strobe)    out_score_outside .. out_all_empty
//   config   psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A curve point is taken whenever start is high while the block is idle.
// After the last point the block is busy for the lookup pass, the error
// pass with a division in the shared divider for each point inside the
// interval that needs one, and up to two final divisions. Reset is
// synchronous and active low. The receiver cannot stall; each result
// transfer lasts one cycle.
// ----------------------------------------------------------------------------
module interval_censored_brier_score
  import icbs_pkg::*;
#(
  parameter int MAX_TIMES = MAX_TIMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [TIME_W-1:0]     in_left_bound,
  input  logic [TIME_W-1:0]     in_right_bound,
  input  logic                  in_right_infinite,
  input  logic [TIME_W-1:0]     in_time_point,
  input  logic                  in_time_infinite,
  input  logic [SURV_W-1:0]     in_surv_value,
  input  logic                  in_last_point,
  output logic                  out_valid,
  output logic [SURV_W-1:0]     out_score_outside,
  output logic [SURV_W-1:0]     out_score_all,
  output logic                  out_outside_empty,
  output logic                  out_all_empty,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [TIME_W-1:0] horizon_r;
  logic              accept;
  cmd_t              cmd;
  status_t           sts;

  assign pready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= HORIZON_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HORIZON)) begin
      horizon_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_HORIZON) ? horizon_r : '0;

  icbs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (accept),
    .in_last_point (in_last_point),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy)
  );

  icbs_dp #(
    .MAX_TIMES (MAX_TIMES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .horizon           (horizon_r),
    .in_left_bound     (in_left_bound),
    .in_right_bound    (in_right_bound),
    .in_right_infinite (in_right_infinite),
    .in_time_point     (in_time_point),
    .in_time_infinite  (in_time_infinite),
    .in_surv_value     (in_surv_value),
    .out_valid         (out_valid),
    .out_score_outside (out_score_outside),
    .out_score_all     (out_score_all),
    .out_outside_empty (out_outside_empty),
    .out_all_empty     (out_all_empty)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_busy_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_last_point))
    else $error("Block became busy without a last point transfer.");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("Result appeared outside the end of a scoring run.");

endmodule
